@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL.
// Simulation gets the checks; synthesis gets empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// prop must hold at every clock edge outside reset
`define ASSERT_AT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
// cond must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

@@ hdl/rpkl_pkg.sv @@
`timescale 1ns / 1ps
package rpkl_pkg;

    localparam int BYTE_W      = 8;
    localparam int OFFSET_W    = 6;
    localparam int ROW_W       = 3;
    localparam int DIGIT_W     = 3;

    // default number of reads a latched key is kept for
    localparam int HOLD_READS_DEF = 8;

    // bus access kind
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // register offsets in the I/O window
    localparam logic [OFFSET_W-1:0] OFF_A_DATA = 6'd0;
    localparam logic [OFFSET_W-1:0] OFF_A_DIR  = 6'd1;
    localparam logic [OFFSET_W-1:0] OFF_B_DATA = 6'd2;
    localparam logic [OFFSET_W-1:0] OFF_B_DIR  = 6'd3;

    // keypad rows selected by port B bits 2:0
    localparam logic [ROW_W-1:0] ROW_FIRST  = 3'd1;
    localparam logic [ROW_W-1:0] ROW_SECOND = 3'd3;
    localparam logic [ROW_W-1:0] ROW_THIRD  = 3'd5;
    localparam logic [ROW_W-1:0] ROW_MODE   = 3'd7;

    // first key code of each keypad row
    localparam logic [BYTE_W-1:0] BASE_FIRST  = 8'd0;
    localparam logic [BYTE_W-1:0] BASE_SECOND = 8'd7;
    localparam logic [BYTE_W-1:0] BASE_THIRD  = 8'd14;

    localparam logic [BYTE_W-1:0] KEY_NONE     = 8'hFF;
    localparam logic [BYTE_W-1:0] ALL_ONES     = 8'hFF;
    localparam logic [BYTE_W-1:0] SERIAL_SENSE = 8'hFE;
    localparam logic [BYTE_W-1:0] COL_TOP      = 8'h40;
    localparam logic [BYTE_W-1:0] MAX_SHIFT    = 8'd6;
    localparam logic [BYTE_W-1:0] DIGIT_BIAS   = 8'd9;

    localparam logic MODE_KEYPAD = 1'b1;

endpackage

@@ hdl/rpkl_key_decode.sv @@
`timescale 1ns / 1ps
// Keypad column pattern for a port A read, masked to the input pins.
module rpkl_key_decode (
    input  logic [rpkl_pkg::BYTE_W-1:0] i_key,
    input  logic [rpkl_pkg::ROW_W-1:0]  i_row,
    input  logic                        i_mode,
    input  logic [rpkl_pkg::BYTE_W-1:0] i_a_dir,
    output logic [rpkl_pkg::BYTE_W-1:0] o_data
);
    import rpkl_pkg::*;

    logic [BYTE_W-1:0] base;
    logic              keyed_row;
    logic [BYTE_W-1:0] shift;
    logic [BYTE_W-1:0] raw;

    always_comb begin
        base      = BASE_FIRST;
        keyed_row = 1'b0;
        case (i_row)
            ROW_FIRST: begin
                base      = BASE_FIRST;
                keyed_row = 1'b1;
            end
            ROW_SECOND: begin
                base      = BASE_SECOND;
                keyed_row = 1'b1;
            end
            ROW_THIRD: begin
                base      = BASE_THIRD;
                keyed_row = 1'b1;
            end
            default: begin
                base      = BASE_FIRST;
                keyed_row = 1'b0;
            end
        endcase

        shift = i_key - base;

        if (keyed_row) begin
            // key outside this row reads as no column pulled low
            if (i_key < base || shift > MAX_SHIFT) begin
                raw = ALL_ONES;
            end else begin
                raw = ~(COL_TOP >> shift[2:0]);
            end
        end else if (i_row == ROW_MODE) begin
            raw = (i_mode == MODE_KEYPAD) ? ALL_ONES : SERIAL_SENSE;
        end else begin
            raw = ALL_ONES;
        end

        o_data = raw & ~i_a_dir;
    end

endmodule

@@ hdl/riot_port_keypad_led_io_unit.sv @@
`timescale 1ns / 1ps
// Two 8-bit RIOT-style I/O ports with keypad scan and LED display hookup.
// Input channel (i_in_valid / o_in_stall): one bus access word per accept,
//   carrying op, reg_offset, write_data and the host key code.
// Output channel (o_out_valid / i_out_stall): one result word per access,
//   with read data, display update info and the key release flag.
// Config: i_cfg_we writes i_cfg_wdata into the keypad/LED mode bit; write it
//   only while no access is in flight (the block does not enforce this).
// An accepted access passes the input register, then the result register,
//   before its result is valid. Throughput: one access per cycle while the
//   receiver does not stall a full result register; the only path is the
//   register mux, the key hold counter and the row decoder.
// Stall: while the receiver stalls a full result register, the input
//   register holds its word and o_in_stall rises, so nothing is dropped.
//   The result register still frees in the same cycle it is taken.
// Reset (synchronous, active low): ports A/B data and B direction clear,
//   A direction goes to all outputs, key hold idle, mode = keypad/LED.
//   Both pipeline registers empty; no clearing pass is needed.
`include "assert_macros.svh"
module riot_port_keypad_led_io_unit #(
    parameter int HOLD_READS = rpkl_pkg::HOLD_READS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_op,
    input  logic [rpkl_pkg::OFFSET_W-1:0]  i_reg_offset,
    input  logic [rpkl_pkg::BYTE_W-1:0]    i_write_data,
    input  logic [rpkl_pkg::BYTE_W-1:0]    i_key_code,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [rpkl_pkg::BYTE_W-1:0]    o_read_data,
    output logic                           o_display_update,
    output logic [rpkl_pkg::DIGIT_W-1:0]   o_digit_index,
    output logic [rpkl_pkg::BYTE_W-1:0]    o_segment_bits,
    output logic [rpkl_pkg::BYTE_W-1:0]    o_port_b_value,
    output logic                           o_key_release
);
    import rpkl_pkg::*;

    localparam int CNT_W = $clog2(HOLD_READS + 1);
    localparam logic [CNT_W-1:0] HOLD_INIT = CNT_W'(HOLD_READS);

    // handshake
    logic out_free;
    logic s1_fire;
    logic in_fire;

    // input register
    logic                r_s1_valid;
    logic                r_op;
    logic [OFFSET_W-1:0] r_offset;
    logic [BYTE_W-1:0]   r_wdata;
    logic [BYTE_W-1:0]   r_key_code;

    // port and key hold state
    logic              r_mode;
    logic [BYTE_W-1:0] r_a_data, n_a_data;
    logic [BYTE_W-1:0] r_a_dir,  n_a_dir;
    logic [BYTE_W-1:0] r_b_data, n_b_data;
    logic [BYTE_W-1:0] r_b_dir,  n_b_dir;
    logic              r_holding, n_holding;
    logic [CNT_W-1:0]  r_hold_cnt, n_hold_cnt;
    logic [BYTE_W-1:0] r_held_key, n_held_key;

    // result register
    logic               r_out_valid;
    logic [BYTE_W-1:0]  r_read_data,  n_read_data;
    logic               r_upd,        n_upd;
    logic [DIGIT_W-1:0] r_digit,      n_digit;
    logic [BYTE_W-1:0]  r_seg,        n_seg;
    logic [BYTE_W-1:0]  r_pb,         n_pb;
    logic               r_rel,        n_rel;

    logic [BYTE_W-1:0] key_used;
    logic [BYTE_W-1:0] keypad_data;
    logic [BYTE_W-1:0] digit_diff;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_fire    = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_fire    = i_in_valid && !o_in_stall;

    rpkl_key_decode u_key_decode (
        .i_key   (key_used),
        .i_row   (r_b_data[ROW_W-1:0]),
        .i_mode  (r_mode),
        .i_a_dir (r_a_dir),
        .o_data  (keypad_data)
    );

    always_comb begin
        n_a_data    = r_a_data;
        n_a_dir     = r_a_dir;
        n_b_data    = r_b_data;
        n_b_dir     = r_b_dir;
        n_holding   = r_holding;
        n_hold_cnt  = r_hold_cnt;
        n_held_key  = r_held_key;
        n_read_data = '0;
        n_upd       = 1'b0;
        n_digit     = '0;
        n_seg       = '0;
        n_pb        = '0;
        n_rel       = 1'b0;
        key_used    = r_key_code;
        digit_diff  = '0;

        if (r_op == OP_WRITE) begin
            n_upd = 1'b1;
            case (r_offset)
                OFF_A_DATA: n_a_data = r_wdata;
                OFF_A_DIR:  n_a_dir  = r_wdata;
                OFF_B_DATA: n_b_data = r_wdata & r_b_dir;
                OFF_B_DIR:  n_b_dir  = r_wdata;
                default:    n_upd    = 1'b0;
            endcase
            if (n_upd) begin
                // digit select is ((B - 9) >> 1) & 7, wrapping at 8 bits
                digit_diff = n_b_data - DIGIT_BIAS;
                n_digit    = digit_diff[DIGIT_W:1];
                n_seg      = n_a_data & n_a_dir;
                n_pb       = n_b_data;
            end
        end else begin
            // every read steps the key hold
            if (r_holding) begin
                key_used   = r_held_key;
                n_hold_cnt = r_hold_cnt - 1'b1;
                if (n_hold_cnt == '0) begin
                    n_holding = 1'b0;
                    n_rel     = 1'b1;
                end
            end else begin
                key_used   = r_key_code;
                n_held_key = r_key_code;
                if (r_key_code != KEY_NONE) begin
                    n_holding  = 1'b1;
                    n_hold_cnt = HOLD_INIT;
                end
            end
            case (r_offset)
                OFF_A_DATA: n_read_data = keypad_data;
                OFF_A_DIR:  n_read_data = r_a_dir;
                OFF_B_DATA: n_read_data = r_b_data & ~r_b_dir;
                OFF_B_DIR:  n_read_data = r_b_dir;
                default:    n_read_data = ALL_ONES;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= MODE_KEYPAD;
            r_a_data    <= '0;
            r_a_dir     <= ALL_ONES;
            r_b_data    <= '0;
            r_b_dir     <= '0;
            r_holding   <= 1'b0;
            r_hold_cnt  <= '0;
            r_held_key  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end

            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_fire) begin
                r_out_valid <= 1'b1;
                r_a_data    <= n_a_data;
                r_a_dir     <= n_a_dir;
                r_b_data    <= n_b_data;
                r_b_dir     <= n_b_dir;
                r_holding   <= n_holding;
                r_hold_cnt  <= n_hold_cnt;
                r_held_key  <= n_held_key;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op       <= i_op;
            r_offset   <= i_reg_offset;
            r_wdata    <= i_write_data;
            r_key_code <= i_key_code;
        end
        if (s1_fire) begin
            r_read_data <= n_read_data;
            r_upd       <= n_upd;
            r_digit     <= n_digit;
            r_seg       <= n_seg;
            r_pb        <= n_pb;
            r_rel       <= n_rel;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_read_data      = r_read_data;
    assign o_display_update = r_upd;
    assign o_digit_index    = r_digit;
    assign o_segment_bits   = r_seg;
    assign o_port_b_value   = r_pb;
    assign o_key_release    = r_rel;

    `ASSERT_AT(a_hold_cnt_live, i_clk, i_rst_n, r_holding |-> (r_hold_cnt != '0))
    `ASSERT_AT(a_idle_cnt_zero, i_clk, i_rst_n, !r_holding |-> (r_hold_cnt == '0))
    `ASSERT_AT(a_release_ends_hold, i_clk, i_rst_n,
               (o_out_valid && o_key_release) |-> !r_holding)
    `ASSERT_NEVER(a_update_is_write, i_clk, i_rst_n,
                  o_out_valid && o_display_update && (o_read_data != '0 || o_key_release))
    `ASSERT_NEVER(a_stall_needs_word, i_clk, i_rst_n, o_in_stall && !r_s1_valid)

endmodule
